[rtl/text_console_pixel_renderer_macros.svh]
// ----------------------------------------------------------------------------
// text_console_pixel_renderer_macros
// Assertion helpers for the text console pixel renderer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_PIXEL_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_PIXEL_RENDERER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCPR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpr same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TCPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpr next-cycle check failed");

`endif

[rtl/tcpr_pkg.sv]
// ----------------------------------------------------------------------------
// tcpr_pkg
// Shared types and constants of the text console pixel renderer.
// ----------------------------------------------------------------------------
package tcpr_pkg;

   // transaction field widths
   localparam int FUNC_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int PIXEL_X_W   = 9;
   localparam int PIXEL_Y_W   = 8;
   localparam int FONT_ADDR_W = 12;
   localparam int FONT_DATA_W = 8;
   localparam int COLOR_W     = 16;
   localparam int CSR_INDEX_W = 1;

   // glyph store size
   localparam int FONT_BYTES = 4096;

   // character codes
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'd13;

   // register reset values
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET       = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RESET = 16'h0000;

   // request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_FONT  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLOR       = 1'b0,
      CSR_BACKGROUND_COLOR = 1'b1
   } csr_index_type;

endpackage

[rtl/tcpr_if.sv]
// ----------------------------------------------------------------------------
// tcpr_if
// Request and response channels of the text console pixel renderer.
// ----------------------------------------------------------------------------
interface tcpr_req_if;
   logic                               valid;
   logic                               ready;
   logic [tcpr_pkg::FUNC_W-1:0]        func;
   logic [tcpr_pkg::CHAR_W-1:0]        char_code;
   logic [tcpr_pkg::PIXEL_X_W-1:0]     pixel_x;
   logic [tcpr_pkg::PIXEL_Y_W-1:0]     pixel_y;
   logic [tcpr_pkg::FONT_ADDR_W-1:0]   font_address;
   logic [tcpr_pkg::FONT_DATA_W-1:0]   font_data;

   modport source (
      output valid, func, char_code, pixel_x, pixel_y, font_address, font_data,
      input  ready
   );
   modport sink (
      input  valid, func, char_code, pixel_x, pixel_y, font_address, font_data,
      output ready
   );
endinterface

interface tcpr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tcpr_pkg::COLOR_W-1:0]   pixel_color;
   logic                           pixel_lit;

   modport source (
      output valid, pixel_color, pixel_lit,
      input  ready
   );
   modport sink (
      input  valid, pixel_color, pixel_lit,
      output ready
   );
endinterface

[rtl/tcpr_cursor.sv]
// ----------------------------------------------------------------------------
// tcpr_cursor
// Write cursor of the character grid: wraps, newline, return and the cell
// write address for printable codes.
// ----------------------------------------------------------------------------
module tcpr_cursor #(
   parameter  int GRID_COLS = 40,
   parameter  int GRID_ROWS = 15,
   localparam int CELLS_D   = (GRID_COLS * GRID_ROWS < 1) ? 1 : GRID_COLS * GRID_ROWS,
   localparam int CAW       = (CELLS_D > 1) ? $clog2(CELLS_D) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          put_en,
   input  logic                          clear_en,
   input  logic [tcpr_pkg::CHAR_W-1:0]   code,
   output logic                          wr_en,
   output logic [CAW-1:0]                wr_addr
);

   localparam int CCW = $clog2(GRID_COLS + 1) < 1 ? 1 : $clog2(GRID_COLS + 1);
   localparam int RW  = $clog2(GRID_ROWS + 1) < 1 ? 1 : $clog2(GRID_ROWS + 1);
   localparam int BSW = $clog2(CELLS_D + 1);

   logic [CCW-1:0] col_ff,  col_in,  col_w;
   logic [RW-1:0]  row_ff,  row_in,  row_w;
   logic [BSW-1:0] base_ff, base_in, base_w;
   logic           printable;

   // cursor update for one put transaction
   always_comb begin
      col_w  = col_ff;
      row_w  = row_ff;
      base_w = base_ff;
      // full row wraps before anything else
      if (col_ff >= CCW'(GRID_COLS)) begin
         col_w = '0;
         if (row_ff < RW'(GRID_ROWS)) begin
            row_w  = row_ff + RW'(1);
            base_w = base_ff + BSW'(GRID_COLS);
         end
      end
      col_in    = col_w;
      row_in    = row_w;
      base_in   = base_w;
      printable = (code >= tcpr_pkg::SPACE_CODE) && !code[tcpr_pkg::CHAR_W-1];
      wr_en     = 1'b0;
      wr_addr   = CAW'(base_w + BSW'(col_w));
      if (row_w < RW'(GRID_ROWS)) begin
         priority if (code == tcpr_pkg::NEWLINE_CODE) begin
            col_in  = '0;
            row_in  = row_w + RW'(1);
            base_in = base_w + BSW'(GRID_COLS);
         end else if (code == tcpr_pkg::RETURN_CODE) begin
            col_in = '0;
         end else if (printable) begin
            wr_en  = put_en;
            col_in = col_w + CCW'(1);
         end else begin
            // other codes leave the cursor where the wrap put it
            col_in = col_w;
         end
      end
   end

   // cursor registers
   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else if (put_en) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

endmodule

[rtl/text_console_pixel_renderer.sv]
// ----------------------------------------------------------------------------
// text_console_pixel_renderer
// Text-mode console: a grid of character cells, a write cursor and a glyph
// store, queried one screen pixel at a time.
//
// req_bus carries put-character, pixel-query, font-byte-write and clear
// transactions; only a pixel query returns a transaction on rsp_bus, with
// its colour and lit flag. Colours are set through the csr_ write port; the
// user must do so while the block is idle, which the block does not enforce.
// Transactions run through a five-register pipeline in order, so one can be
// accepted every cycle while no clear, sweep or rsp_bus stall holds it off;
// a query result passes the stage 1 to stage 4 registers and the output
// register on its way to rsp_bus. Cell and glyph stores are memories with one
// write and one read port, used in fixed stages, which keeps writes and later reads in order.
// A clear holds off new requests until it reaches the cell store, then a
// sweep writes spaces, one cell a cycle, over all (SCREEN_W/CELL_W) *
// (SCREEN_H/GLYPH_H) cells of the grid.
// After reset the same sweep runs before the first request is taken.
// When rsp_bus stalls the whole pipeline holds and req_bus.ready drops.
// ----------------------------------------------------------------------------
`include "text_console_pixel_renderer_macros.svh"

module text_console_pixel_renderer #(
   parameter int SCREEN_W    = 320,
   parameter int SCREEN_H    = 240,
   parameter int GLYPH_W     = 8,
   parameter int CELL_W      = 8,
   parameter int GLYPH_H     = 16,
   parameter int GLYPH_COUNT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   tcpr_req_if.sink                           req_bus,
   tcpr_rsp_if.source                         rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [tcpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcpr_pkg::COLOR_W-1:0]       csr_wdata
);

   // grid geometry
   localparam int GRID_COLS   = SCREEN_W / CELL_W;
   localparam int GRID_ROWS   = SCREEN_H / GLYPH_H;
   localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
   localparam int CELLS_D     = (GRID_CELLS < 1) ? 1 : GRID_CELLS;
   localparam int CAW         = (CELLS_D > 1) ? $clog2(CELLS_D) : 1;
   localparam int GLYPH_BYTES = (GLYPH_W * GLYPH_H + 7) / 8;

   // field widths
   localparam int XW  = tcpr_pkg::PIXEL_X_W;
   localparam int YW  = tcpr_pkg::PIXEL_Y_W;
   localparam int FAW = tcpr_pkg::FONT_ADDR_W;
   localparam int FDW = tcpr_pkg::FONT_DATA_W;
   localparam int CW  = tcpr_pkg::CHAR_W;
   localparam int CLW = tcpr_pkg::COLOR_W;

   // reciprocal multipliers for x / CELL_W and y / GLYPH_H
   localparam int XL  = $clog2(CELL_W);
   localparam int XS  = XW + XL;
   localparam int XM  = ((1 << XS) + CELL_W - 1) / CELL_W;
   localparam int XPW = XW + XW + 2;
   localparam int YL  = $clog2(GLYPH_H);
   localparam int YS  = YW + YL;
   localparam int YM  = ((1 << YS) + GLYPH_H - 1) / GLYPH_H;
   localparam int YPW = YW + YW + 2;

   // in-cell offsets and glyph bit position
   localparam int IW = (CELL_W > 1) ? $clog2(CELL_W) : 1;
   localparam int JW = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
   localparam int BW = ($clog2(GLYPH_W * GLYPH_H) < 3) ? 3 : $clog2(GLYPH_W * GLYPH_H);

   // memories
   logic [CW-1:0]  text_mem [CELLS_D];
   logic [FDW-1:0] font_mem [tcpr_pkg::FONT_BYTES];

   // control
   logic            advance;
   logic            req_accept;
   logic            sweep_ff;
   logic [CAW-1:0]  sweep_cnt_ff;
   logic            hold_ff;
   logic            clear_go;
   logic            s2_put;
   logic            put_go;
   logic            cur_wen;
   logic [CAW-1:0]  cur_waddr;
   tcpr_pkg::func_type req_func;

   // configuration
   logic [CLW-1:0] text_color_ff;
   logic [CLW-1:0] background_color_ff;

   // stage 1: accepted request and reciprocal products
   logic                  s1_vld_ff;
   tcpr_pkg::func_type    s1_func_ff;
   logic [CW-1:0]         s1_char_ff;
   logic [XW-1:0]         s1_x_ff;
   logic [YW-1:0]         s1_y_ff;
   logic [FAW-1:0]        s1_faddr_ff;
   logic [FDW-1:0]        s1_fdata_ff;
   logic [XPW-1:0]        s1_px_ff;
   logic [YPW-1:0]        s1_py_ff;

   // stage 2: cell address and offsets
   logic                  s2_vld_ff;
   tcpr_pkg::func_type    s2_func_ff;
   logic [CW-1:0]         s2_char_ff;
   logic [FAW-1:0]        s2_faddr_ff;
   logic [FDW-1:0]        s2_fdata_ff;
   logic [CAW-1:0]        s2_cell_addr_ff;
   logic                  s2_in_grid_ff;
   logic                  s2_blank_ff;
   logic [IW-1:0]         s2_i_ff;
   logic [JW-1:0]         s2_j_ff;

   // stage 3: cell code read, bit position
   logic                  s3_vld_ff;
   tcpr_pkg::func_type    s3_func_ff;
   logic [FAW-1:0]        s3_faddr_ff;
   logic [FDW-1:0]        s3_fdata_ff;
   logic                  s3_in_grid_ff;
   logic                  s3_blank_ff;
   logic [BW-1:0]         s3_bitpos_ff;
   logic [CW-1:0]         tdata_ff;

   // stage 4: glyph byte read
   logic                  s4_vld_ff;
   logic                  s4_blank_ff;
   logic [2:0]            s4_bit_ff;
   logic [FDW-1:0]        fdata_ff;

   // output register
   logic                  rsp_vld_ff;
   logic [CLW-1:0]        rsp_color_ff;
   logic                  rsp_lit_ff;

   // stage-boundary logic
   logic [XW-1:0]  b_col;
   logic [YW-1:0]  b_row;
   logic [IW-1:0]  b_i;
   logic [JW-1:0]  b_j;
   logic [CAW-1:0] b_cell_addr;
   logic           b_in_grid;
   logic           b_offscreen;
   logic           b_gap;
   logic [BW-1:0]  c_bitpos;
   logic [CW-1:0]  d_code;
   logic           d_code_bad;
   logic [FAW-1:0] font_raddr;
   logic           e_lit;

   // handshake
   assign advance       = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = advance && !sweep_ff && !hold_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_func      = tcpr_pkg::func_type'(req_bus.func);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff       <= tcpr_pkg::TEXT_COLOR_RESET;
         background_color_ff <= tcpr_pkg::BACKGROUND_COLOR_RESET;
      end else if (csr_wr_en) begin
         unique case (tcpr_pkg::csr_index_type'(csr_index))
            tcpr_pkg::CSR_TEXT_COLOR:       text_color_ff       <= csr_wdata;
            tcpr_pkg::CSR_BACKGROUND_COLOR: background_color_ff <= csr_wdata;
         endcase
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= req_accept;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff && (s3_func_ff == tcpr_pkg::FUNC_QUERY);
         rsp_vld_ff <= s4_vld_ff;
      end
   end

   // stage 1 load: reciprocal products of the pixel coordinates
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff  <= req_func;
         s1_char_ff  <= req_bus.char_code;
         s1_x_ff     <= req_bus.pixel_x;
         s1_y_ff     <= req_bus.pixel_y;
         s1_faddr_ff <= req_bus.font_address;
         s1_fdata_ff <= req_bus.font_data;
         s1_px_ff    <= XPW'(req_bus.pixel_x) * XPW'(XM);
         s1_py_ff    <= YPW'(req_bus.pixel_y) * YPW'(YM);
      end
   end

   // cell coordinates, in-cell offsets and cell address
   always_comb begin
      b_col       = XW'(s1_px_ff >> XS);
      b_row       = YW'(s1_py_ff >> YS);
      b_i         = IW'(s1_x_ff - b_col * XW'(CELL_W));
      b_j         = JW'(s1_y_ff - b_row * YW'(GLYPH_H));
      b_cell_addr = CAW'(b_row) * CAW'(GRID_COLS) + CAW'(b_col);
      b_in_grid   = (32'(b_row) < GRID_ROWS) && (32'(b_col) < GRID_COLS);
      b_offscreen = (32'(s1_x_ff) >= SCREEN_W) || (32'(s1_y_ff) >= SCREEN_H);
      b_gap       = 32'(b_i) >= GLYPH_W;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_func_ff      <= s1_func_ff;
         s2_char_ff      <= s1_char_ff;
         s2_faddr_ff     <= s1_faddr_ff;
         s2_fdata_ff     <= s1_fdata_ff;
         s2_cell_addr_ff <= b_cell_addr;
         s2_in_grid_ff   <= b_in_grid;
         s2_blank_ff     <= b_offscreen || b_gap;
         s2_i_ff         <= b_i;
         s2_j_ff         <= b_j;
      end
   end

   // cursor and clear control at the cell store stage
   assign s2_put   = s2_vld_ff && (s2_func_ff == tcpr_pkg::FUNC_PUT);
   assign put_go   = advance && s2_put;
   assign clear_go = advance && s2_vld_ff && (s2_func_ff == tcpr_pkg::FUNC_CLEAR);

   tcpr_cursor #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .put_en   (put_go),
      .clear_en (clear_go),
      .code     (s2_char_ff),
      .wr_en    (cur_wen),
      .wr_addr  (cur_waddr)
   );

   // clear hold-off and space sweep over the cell store
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         hold_ff      <= 1'b0;
      end else begin
         if (req_accept && (req_func == tcpr_pkg::FUNC_CLEAR)) begin
            hold_ff <= 1'b1;
         end
         priority if (clear_go) begin
            hold_ff      <= 1'b0;
            sweep_ff     <= 1'b1;
            sweep_cnt_ff <= '0;
         end else if (sweep_ff) begin
            if (sweep_cnt_ff == CAW'(CELLS_D - 1)) begin
               sweep_ff <= 1'b0;
            end
            sweep_cnt_ff <= sweep_cnt_ff + CAW'(1);
         end else begin
            sweep_cnt_ff <= '0;
         end
      end
   end

   // cell store: sweep or put writes, query reads
   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         text_mem[sweep_cnt_ff] <= tcpr_pkg::SPACE_CODE;
      end else if (cur_wen) begin
         text_mem[cur_waddr] <= s2_char_ff;
      end
      if (advance) begin
         tdata_ff <= text_mem[s2_cell_addr_ff];
      end
   end

   // glyph bit position within the glyph bitmap
   assign c_bitpos = BW'(s2_i_ff) + BW'(s2_j_ff) * BW'(GLYPH_W);

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_func_ff    <= s2_func_ff;
         s3_faddr_ff   <= s2_faddr_ff;
         s3_fdata_ff   <= s2_fdata_ff;
         s3_in_grid_ff <= s2_in_grid_ff;
         s3_blank_ff   <= s2_blank_ff;
         s3_bitpos_ff  <= c_bitpos;
      end
   end

   // glyph byte address; cells off the grid show a space
   always_comb begin
      d_code     = s3_in_grid_ff ? tdata_ff : tcpr_pkg::SPACE_CODE;
      d_code_bad = 32'(d_code) >= GLYPH_COUNT;
      font_raddr = FAW'(32'(d_code) * GLYPH_BYTES) + FAW'(s3_bitpos_ff >> 3);
   end

   // glyph store: font writes and query reads
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s3_vld_ff && (s3_func_ff == tcpr_pkg::FUNC_FONT)) begin
            font_mem[s3_faddr_ff] <= s3_fdata_ff;
         end
         fdata_ff <= font_mem[font_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_blank_ff <= s3_blank_ff || d_code_bad;
         s4_bit_ff   <= s3_bitpos_ff[2:0];
      end
   end

   // pixel colour
   assign e_lit = !s4_blank_ff && fdata_ff[s4_bit_ff];

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_color_ff <= e_lit ? text_color_ff : background_color_ff;
         rsp_lit_ff   <= e_lit;
      end
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.pixel_color = rsp_color_ff;
   assign rsp_bus.pixel_lit   = rsp_lit_ff;

   // checks
   `TCPR_ASSERT_IMPLIES(a_cell_write_in_grid, clock, reset, cur_wen, 32'(cur_waddr) < GRID_CELLS)
   `TCPR_ASSERT_IMPLIES(a_no_put_during_sweep, clock, reset, sweep_ff, !s2_put)
   `TCPR_ASSERT_NEXT(a_clear_starts_sweep, clock, reset, clear_go, sweep_ff && (sweep_cnt_ff == '0))

endmodule

[tb/sv/tb_text_console_pixel_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_pixel_renderer
// Self-checking bench for the text console pixel renderer.
//
// A short table of directed transactions covers the field extremes, every
// function, control and ignored codes, clearing and off-screen pixels. Then
// random transactions follow: typed lines that wrap and run past the bottom
// row, pixel probes, glyph loads and clears. A behavioral copy of the console
// or the table predicts each pixel response, compared field by field in order.
// Idle gaps on both sides change between phases, as do the two colors.
// ----------------------------------------------------------------------------
module tb_text_console_pixel_renderer;

   // geometry of the default build
   localparam int SCREEN_W    = 320;
   localparam int SCREEN_H    = 240;
   localparam int GLYPH_W     = 8;
   localparam int CELL_W      = 8;
   localparam int GLYPH_H     = 16;
   localparam int GLYPH_COUNT = 256;
   localparam int GRID_COLS   = SCREEN_W / CELL_W;
   localparam int GRID_ROWS   = SCREEN_H / GLYPH_H;
   localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
   localparam int GLYPH_BYTES = (GLYPH_W * GLYPH_H + 7) / 8;
   localparam int FONT_BYTES  = tcpr_pkg::FONT_BYTES;

   localparam int PIPE_SETTLE    = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 175;

   typedef struct {
      tcpr_pkg::func_type                   op;
      logic [tcpr_pkg::CHAR_W-1:0]          code;
      logic [tcpr_pkg::PIXEL_X_W-1:0]       px;
      logic [tcpr_pkg::PIXEL_Y_W-1:0]       py;
      logic [tcpr_pkg::FONT_ADDR_W-1:0]     faddr;
      logic [tcpr_pkg::FONT_DATA_W-1:0]     fdata;
      bit                                   typed;
      logic [tcpr_pkg::COLOR_W-1:0]         want_color;
      logic                                 want_lit;
   } console_req_type;

   typedef struct {
      logic [tcpr_pkg::COLOR_W-1:0] color;
      logic                         lit;
   } pixel_result_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_wr_en;
   logic [tcpr_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [tcpr_pkg::COLOR_W-1:0]         csr_wdata;

   tcpr_req_if req_bus ();
   tcpr_rsp_if rsp_bus ();

   text_console_pixel_renderer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // console shadow state
   logic [tcpr_pkg::CHAR_W-1:0]      cell_chars [GRID_CELLS];
   logic [tcpr_pkg::FONT_DATA_W-1:0] glyph_bytes [FONT_BYTES];
   bit                               glyph_written [FONT_BYTES];
   logic [5:0]                       cur_col;
   logic [4:0]                       cur_row;
   logic [tcpr_pkg::COLOR_W-1:0]     fg_color;
   logic [tcpr_pkg::COLOR_W-1:0]     bg_color;

   pixel_result_type expected_pixels [$];
   console_req_type  directed_rows [$];
   int               applied_count;
   int               error_count = 0;
   int               stall_cycles = 0;
   int               send_idle_pct;
   int               recv_idle_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic console_req_type mk(tcpr_pkg::func_type op, int a = 0, int b = 0,
                                          bit typed = 1'b0, int color = 0, bit lit = 1'b0);
      console_req_type r;
      r.op         = op;
      r.code       = a[tcpr_pkg::CHAR_W-1:0];
      r.px         = a[tcpr_pkg::PIXEL_X_W-1:0];
      r.py         = b[tcpr_pkg::PIXEL_Y_W-1:0];
      r.faddr      = a[tcpr_pkg::FONT_ADDR_W-1:0];
      r.fdata      = b[tcpr_pkg::FONT_DATA_W-1:0];
      r.typed      = typed;
      r.want_color = color[tcpr_pkg::COLOR_W-1:0];
      r.want_lit   = lit;
      return r;
   endfunction

   // glyph byte that a pixel reads, -1 when none is read
   function automatic int glyph_byte_addr(int x, int y);
      int row;
      int col;
      int code;
      int bitpos;
      if (x >= SCREEN_W || y >= SCREEN_H) return -1;
      row  = y / GLYPH_H;
      col  = x / CELL_W;
      code = tcpr_pkg::SPACE_CODE;
      if (row < GRID_ROWS && col < GRID_COLS) code = cell_chars[row * GRID_COLS + col];
      if (x % CELL_W >= GLYPH_W || code >= GLYPH_COUNT) return -1;
      bitpos = (x % CELL_W) + (y % GLYPH_H) * GLYPH_W;
      return (code * GLYPH_BYTES + bitpos / 8) % FONT_BYTES;
   endfunction

   // update the shadow console with one accepted transaction
   function automatic void apply_request(console_req_type r);
      int               addr;
      int               bitpos;
      pixel_result_type res;
      applied_count++;
      case (r.op)
         tcpr_pkg::FUNC_PUT: begin
            if (cur_col >= GRID_COLS) begin
               cur_col = 0;
               if (cur_row < GRID_ROWS) cur_row++;
            end
            if (cur_row < GRID_ROWS) begin
               if (r.code == tcpr_pkg::NEWLINE_CODE) begin
                  cur_col = 0;
                  cur_row++;
               end else if (r.code == tcpr_pkg::RETURN_CODE) begin
                  cur_col = 0;
               end else if (r.code >= tcpr_pkg::SPACE_CODE && r.code < 128) begin
                  cell_chars[cur_row * GRID_COLS + cur_col] = r.code;
                  cur_col++;
               end
            end
         end
         tcpr_pkg::FUNC_QUERY: begin
            addr   = glyph_byte_addr(r.px, r.py);
            bitpos = (r.px % CELL_W) + (r.py % GLYPH_H) * GLYPH_W;
            res.lit   = (addr >= 0) ? glyph_bytes[addr][bitpos % 8] : 1'b0;
            res.color = res.lit ? fg_color : bg_color;
            if (r.typed) begin
               res.color = r.want_color;
               res.lit   = r.want_lit;
            end
            expected_pixels.push_back(res);
         end
         tcpr_pkg::FUNC_FONT: begin
            glyph_bytes[r.faddr]   = r.fdata;
            glyph_written[r.faddr] = 1'b1;
         end
         default: begin
            cell_chars = '{default: tcpr_pkg::SPACE_CODE};
            cur_col    = 0;
            cur_row    = 0;
         end
      endcase
   endfunction

   // send one request transaction, with random idle cycles ahead of it
   task automatic drive(console_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= r.op;
      req_bus.char_code    <= r.code;
      req_bus.pixel_x      <= r.px;
      req_bus.pixel_y      <= r.py;
      req_bus.font_address <= r.faddr;
      req_bus.font_data    <= r.fdata;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      apply_request(r);
   endtask

   // drain all pending pixel responses, then let the pipeline and any sweep end
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic set_colors(logic [tcpr_pkg::COLOR_W-1:0] text_c,
                             logic [tcpr_pkg::COLOR_W-1:0] back_c);
      csr_wr_en <= 1'b1;
      csr_index <= tcpr_pkg::CSR_TEXT_COLOR;
      csr_wdata <= text_c;
      @(posedge clock);
      fg_color  = text_c;
      csr_index <= tcpr_pkg::CSR_BACKGROUND_COLOR;
      csr_wdata <= back_c;
      @(posedge clock);
      bg_color  = back_c;
      csr_wr_en <= 1'b0;
   endtask

   // pixel probe; loads the glyph byte it reads first when still unwritten
   task automatic probe_random();
      int x;
      int y;
      int roll;
      int addr;
      int last_row;
      roll     = $urandom_range(99);
      last_row = (cur_row < GRID_ROWS) ? cur_row : GRID_ROWS - 1;
      if (roll < 8) begin
         x = $urandom_range(0, 511);
         y = $urandom_range(0, 255);
      end else if (roll < 55) begin
         x = $urandom_range(0, SCREEN_W - 1);
         y = $urandom_range(0, last_row * GLYPH_H + GLYPH_H - 1);
      end else begin
         x = $urandom_range(0, SCREEN_W - 1);
         y = $urandom_range(0, SCREEN_H - 1);
      end
      addr = glyph_byte_addr(x, y);
      if (addr >= 0 && !glyph_written[addr])
         drive(mk(tcpr_pkg::FUNC_FONT, addr, $urandom_range(0, 255)));
      drive(mk(tcpr_pkg::FUNC_QUERY, x, y));
   endtask

   // one typed line: printable text with some noise, then a newline, a return or no ending
   task automatic type_line();
      int len;
      int code;
      int ending;
      len = $urandom_range(0, 45);
      for (int k = 0; k < len; k++) begin
         code = ($urandom_range(99) < 8) ? $urandom_range(0, 255) : $urandom_range(32, 127);
         drive(mk(tcpr_pkg::FUNC_PUT, code));
      end
      ending = $urandom_range(99);
      if (ending < 60) drive(mk(tcpr_pkg::FUNC_PUT, tcpr_pkg::NEWLINE_CODE));
      else if (ending < 75) drive(mk(tcpr_pkg::FUNC_PUT, tcpr_pkg::RETURN_CODE));
      repeat ($urandom_range(1, 4)) probe_random();
   endtask

   task automatic run_random(int quota);
      int stop;
      int roll;
      stop = applied_count + quota;
      while (applied_count < stop) begin
         roll = $urandom_range(99);
         if ($urandom_range(99) < ((cur_row >= GRID_ROWS) ? 20 : 2)) begin
            drive(mk(tcpr_pkg::FUNC_CLEAR));
         end else if (roll < 50) begin
            type_line();
         end else if (roll < 80) begin
            repeat ($urandom_range(1, 8)) probe_random();
         end else if (roll < 93) begin
            if ($urandom_range(1))
               drive(mk(tcpr_pkg::FUNC_FONT, $urandom_range(0, FONT_BYTES - 1),
                        $urandom_range(0, 255)));
            else
               drive(mk(tcpr_pkg::FUNC_FONT,
                        $urandom_range(32 * GLYPH_BYTES, 128 * GLYPH_BYTES - 1),
                        $urandom_range(0, 255)));
         end else begin
            drive(mk(tcpr_pkg::FUNC_PUT, $urandom_range(0, 255)));
         end
      end
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin : rsp_check
      pixel_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel transaction with none pending: color %h lit %b",
                                      rsp_bus.pixel_color, rsp_bus.pixel_lit));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.pixel_color !== want.color)
               report_mismatch($sformatf("pixel_color %h, predicted %h",
                                         rsp_bus.pixel_color, want.color));
            if (rsp_bus.pixel_lit !== want.lit)
               report_mismatch($sformatf("pixel_lit %b, predicted %b",
                                         rsp_bus.pixel_lit, want.lit));
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // watchdog
   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // main sequence
   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= tcpr_pkg::CSR_TEXT_COLOR;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.func         <= tcpr_pkg::FUNC_PUT;
      req_bus.char_code    <= '0;
      req_bus.pixel_x      <= '0;
      req_bus.pixel_y      <= '0;
      req_bus.font_address <= '0;
      req_bus.font_data    <= '0;
      applied_count         = 0;
      cell_chars            = '{default: tcpr_pkg::SPACE_CODE};
      glyph_bytes           = '{default: '0};
      glyph_written         = '{default: 1'b0};
      cur_col               = 0;
      cur_row               = 0;
      fg_color              = tcpr_pkg::TEXT_COLOR_RESET;
      bg_color              = tcpr_pkg::BACKGROUND_COLOR_RESET;
      send_idle_pct         = 21;
      recv_idle_pct         = 57;

      // directed transactions
      directed_rows.push_back(mk(tcpr_pkg::FUNC_FONT, tcpr_pkg::SPACE_CODE * GLYPH_BYTES,
                                 8'hA5));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 0, 0, 1'b1,
                                 tcpr_pkg::TEXT_COLOR_RESET, 1'b1));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 1, 0, 1'b1,
                                 tcpr_pkg::BACKGROUND_COLOR_RESET, 1'b0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 7, 0, 1'b1,
                                 tcpr_pkg::TEXT_COLOR_RESET, 1'b1));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 511, 255, 1'b1,
                                 tcpr_pkg::BACKGROUND_COLOR_RESET, 1'b0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, SCREEN_W, 0, 1'b1,
                                 tcpr_pkg::BACKGROUND_COLOR_RESET, 1'b0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 0, SCREEN_H, 1'b1,
                                 tcpr_pkg::BACKGROUND_COLOR_RESET, 1'b0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_FONT, FONT_BYTES - 1, 8'hFF));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_FONT, 65 * GLYPH_BYTES, 8'h81));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, 65));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 0, 0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 7, 0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, tcpr_pkg::RETURN_CODE));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, 127));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_FONT, 127 * GLYPH_BYTES, 8'h3C));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 3, 0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, tcpr_pkg::NEWLINE_CODE));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, 0));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, 255));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, 128));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_PUT, tcpr_pkg::SPACE_CODE));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_CLEAR));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, 0, 0, 1'b1,
                                 tcpr_pkg::TEXT_COLOR_RESET, 1'b1));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_FONT,
                                 tcpr_pkg::SPACE_CODE * GLYPH_BYTES + GLYPH_H - 1, 8'h80));
      directed_rows.push_back(mk(tcpr_pkg::FUNC_QUERY, SCREEN_W - 1, SCREEN_H - 1, 1'b1,
                                 tcpr_pkg::TEXT_COLOR_RESET, 1'b1));

      // reset, then release
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) drive(directed_rows[i]);
      settle();

      // sender idles less than the receiver, extreme colors swapped
      set_colors(16'h0000, 16'hFFFF);
      run_random(PHASE_ITEMS);
      settle();

      // receiver idles less than the sender
      send_idle_pct = 57;
      recv_idle_pct = 21;
      set_colors($urandom_range(0, 65535), $urandom_range(0, 65535));
      run_random(PHASE_ITEMS);
      settle();

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_colors(16'hFFFF, $urandom_range(0, 65535));
      run_random(PHASE_ITEMS);
      settle();

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
